[hdl/accc_pkg.sv]
// Shared types and constants for the aspect-ratio center crop calculator.
`default_nettype none

package accc_pkg;

  localparam int unsigned DimBits   = 16;
  localparam int unsigned ProdBits  = 2 * DimBits;
  localparam int unsigned DivSteps  = DimBits;
  // multiply, compare, one stage per quotient bit, size/remove, split
  localparam int unsigned Latency   = DivSteps + 4;
  localparam int unsigned ShiftBits = 2;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned RegIdxBits = 2;

  localparam logic [RegIdxBits-1:0] RegTargetW = 2'd0;
  localparam logic [RegIdxBits-1:0] RegTargetH = 2'd1;
  localparam logic [RegIdxBits-1:0] RegShiftX  = 2'd2;
  localparam logic [RegIdxBits-1:0] RegShiftY  = 2'd3;

  typedef logic [DimBits-1:0]  dim_t;
  typedef logic [ProdBits-1:0] prod_t;

  typedef enum logic [1:0] {
    MODE_EQUAL = 2'b00,
    MODE_WIDE  = 2'b01,
    MODE_TALL  = 2'b10
  } mode_e;

  typedef struct packed {
    dim_t                 tw;
    dim_t                 th;
    logic [ShiftBits-1:0] sx;
    logic [ShiftBits-1:0] sy;
  } cfg_t;

  typedef struct packed {
    dim_t  w;
    dim_t  h;
    mode_e mode;
    logic  zero;
  } side_t;

  typedef struct packed {
    dim_t left_px;
    dim_t right_px;
    dim_t top_px;
    dim_t bottom_px;
    dim_t width;
    dim_t height;
    logic status;
  } res_t;

endpackage

`default_nettype wire

[hdl/aspect_center_crop_calc_core.sv]
// Top level: register port, cross-product stage, divider and crop split.
//
//  channel   signals                                  direction  handshake
//  request   start, frame_width_i, frame_height_i     in         start && !busy
//  result    crop_*_px_o, cropped_*_o, status_o       out        done_o, one cycle
//  config    psel/penable/pwrite/paddr/pwdata         in         APB, pready tied high
//
// One request per cycle while busy is low; each result follows its request through
// registered multiply and compare stages, 16 divider stages of one quotient bit
// each, then size and split stages. busy is high only while in reset and
// the cycle after. Results cannot be held off; the pipeline never stalls.
`default_nettype none

module aspect_center_crop_calc_core import accc_pkg::*; (
  input  wire  logic                clk_i,
  input  wire  logic                rst_ni,
  input  wire  logic                start,
  output logic                      busy,
  input  wire  logic [DimBits-1:0]  frame_width_i,
  input  wire  logic [DimBits-1:0]  frame_height_i,
  output logic                      done_o,
  output logic [DimBits-1:0]        crop_left_px_o,
  output logic [DimBits-1:0]        crop_right_px_o,
  output logic [DimBits-1:0]        crop_top_px_o,
  output logic [DimBits-1:0]        crop_bottom_px_o,
  output logic [DimBits-1:0]        cropped_width_o,
  output logic [DimBits-1:0]        cropped_height_o,
  output logic                      status_o,
  input  wire  logic                psel,
  input  wire  logic                penable,
  input  wire  logic                pwrite,
  input  wire  logic [AddrBits-1:0] paddr,
  input  wire  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0]       prdata,
  output logic                      pready
);

  cfg_t cfg_q;
  logic busy_q;
  logic wr_en;
  logic [RegIdxBits-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrBits-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tw <= dim_t'(1);
      cfg_q.th <= dim_t'(1);
      cfg_q.sx <= ShiftBits'(1);
      cfg_q.sy <= ShiftBits'(1);
      busy_q   <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (wr_en) begin
        unique case (reg_idx)
          RegTargetW: cfg_q.tw <= pwdata[DimBits-1:0];
          RegTargetH: cfg_q.th <= pwdata[DimBits-1:0];
          RegShiftX:  cfg_q.sx <= pwdata[ShiftBits-1:0];
          RegShiftY:  cfg_q.sy <= pwdata[ShiftBits-1:0];
          default:    cfg_q.tw <= cfg_q.tw;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTargetW: prdata = DataBits'(cfg_q.tw);
      RegTargetH: prdata = DataBits'(cfg_q.th);
      RegShiftX:  prdata = DataBits'(cfg_q.sx);
      RegShiftY:  prdata = DataBits'(cfg_q.sy);
      default:    prdata = '0;
    endcase
  end

  assign busy = busy_q;

  logic  xp_valid;
  prod_t xp_dividend;
  dim_t  xp_divisor;
  side_t xp_side;

  accc_xprod u_xprod (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start && !busy_q),
    .frame_width_i  (frame_width_i),
    .frame_height_i (frame_height_i),
    .cfg_i          (cfg_q),
    .valid_o        (xp_valid),
    .dividend_o     (xp_dividend),
    .divisor_o      (xp_divisor),
    .side_o         (xp_side)
  );

  logic  dv_valid;
  dim_t  dv_quot;
  side_t dv_side;

  accc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (xp_valid),
    .dividend_i (xp_dividend),
    .divisor_i  (xp_divisor),
    .side_i     (xp_side),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  res_t res;

  accc_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .quot_i  (dv_quot),
    .side_i  (dv_side),
    .cfg_i   (cfg_q),
    .valid_o (done_o),
    .res_o   (res)
  );

  assign crop_left_px_o   = res.left_px;
  assign crop_right_px_o  = res.right_px;
  assign crop_top_px_o    = res.top_px;
  assign crop_bottom_px_o = res.bottom_px;
  assign cropped_width_o  = res.width;
  assign cropped_height_o = res.height;
  assign status_o         = res.status;

endmodule

`default_nettype wire

[hdl/accc_xprod.sv]
// Cross-product stage and aspect compare: picks dividend and divisor.
`default_nettype none

module accc_xprod import accc_pkg::*; (
  input  wire  logic  clk_i,
  input  wire  logic  rst_ni,
  input  wire  logic  valid_i,
  input  wire  dim_t  frame_width_i,
  input  wire  dim_t  frame_height_i,
  input  wire  cfg_t  cfg_i,
  output logic        valid_o,
  output prod_t       dividend_o,
  output dim_t        divisor_o,
  output side_t       side_o
);

  logic  v1_q;
  prod_t src_q, dst_q;
  dim_t  w_q, h_q;
  logic  zero_q;

  logic  v2_q;
  prod_t dividend_q;
  dim_t  divisor_q;
  side_t side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= prod_t'(frame_width_i) * prod_t'(cfg_i.th);
    dst_q  <= prod_t'(cfg_i.tw) * prod_t'(frame_height_i);
    w_q    <= frame_width_i;
    h_q    <= frame_height_i;
    zero_q <= (frame_width_i == '0) || (frame_height_i == '0) ||
              (cfg_i.tw == '0) || (cfg_i.th == '0);
  end

  mode_e mode_d;

  always_comb begin
    if (src_q > dst_q) begin
      mode_d = MODE_WIDE;
    end else if (src_q < dst_q) begin
      mode_d = MODE_TALL;
    end else begin
      mode_d = MODE_EQUAL;
    end
  end

  // too wide: new width = h*tw/th; too tall: new height = w*th/tw
  always_ff @(posedge clk_i) begin
    dividend_q  <= (mode_d == MODE_WIDE) ? dst_q : src_q;
    divisor_q   <= (mode_d == MODE_WIDE) ? cfg_i.th : cfg_i.tw;
    side_q.w    <= w_q;
    side_q.h    <= h_q;
    side_q.mode <= mode_d;
    side_q.zero <= zero_q;
  end

  assign valid_o    = v2_q;
  assign dividend_o = dividend_q;
  assign divisor_o  = divisor_q;
  assign side_o     = side_q;

endmodule

`default_nettype wire

[hdl/accc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module accc_div import accc_pkg::*; (
  input  wire  logic  clk_i,
  input  wire  logic  rst_ni,
  input  wire  logic  valid_i,
  input  wire  prod_t dividend_i,
  input  wire  dim_t  divisor_i,
  input  wire  side_t side_i,
  output logic        valid_o,
  output dim_t        quot_o,
  output side_t       side_o
);

  // Quotient is known to fit DimBits, so the upper half of the dividend
  // is already below the divisor and serves as the starting remainder.
  logic  vld  [DivSteps+1];
  dim_t  rem  [DivSteps+1];
  dim_t  num  [DivSteps+1];
  dim_t  quo  [DivSteps+1];
  dim_t  dvs  [DivSteps+1];
  side_t side [DivSteps+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = dividend_i[ProdBits-1:DimBits];
  assign num[0]  = dividend_i[DimBits-1:0];
  assign quo[0]  = '0;
  assign dvs[0]  = divisor_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [DimBits+1:0] diff;
    logic               take;

    assign diff = {1'b0, rem[k], num[k][DimBits-1]} - {2'b00, dvs[k]};
    assign take = !diff[DimBits+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[k+1]  <= take ? diff[DimBits-1:0] : {rem[k][DimBits-2:0], num[k][DimBits-1]};
      num[k+1]  <= {num[k][DimBits-2:0], 1'b0};
      quo[k+1]  <= {quo[k][DimBits-2:0], take};
      dvs[k+1]  <= dvs[k];
      side[k+1] <= side[k];
    end
  end

  assign valid_o = vld[DivSteps];
  assign quot_o  = quo[DivSteps];
  assign side_o  = side[DivSteps];

endmodule

`default_nettype wire

[hdl/accc_split.sv]
// Cropped size, removed amount and aligned leading/trailing split.
`default_nettype none

module accc_split import accc_pkg::*; (
  input  wire  logic  clk_i,
  input  wire  logic  rst_ni,
  input  wire  logic  valid_i,
  input  wire  dim_t  quot_i,
  input  wire  side_t side_i,
  input  wire  cfg_t  cfg_i,
  output logic        valid_o,
  output res_t        res_o
);

  logic                 va_q;
  dim_t                 removed_q, cw_q, ch_q;
  mode_e                mode_q;
  logic                 zero_q;
  logic [ShiftBits-1:0] shift_q;

  logic vb_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  dim_t qf;
  dim_t removed_d, cw_d, ch_d;
  logic [ShiftBits-1:0] shift_d;

  always_comb begin
    qf        = (quot_i == '0) ? dim_t'(1) : quot_i;
    removed_d = '0;
    cw_d      = side_i.w;
    ch_d      = side_i.h;
    shift_d   = cfg_i.sx;
    unique case (side_i.mode)
      MODE_WIDE: begin
        removed_d = side_i.w - qf;
        cw_d      = qf;
      end
      MODE_TALL: begin
        removed_d = side_i.h - qf;
        ch_d      = qf;
        shift_d   = cfg_i.sy;
      end
      default: begin
        removed_d = '0;
      end
    endcase
    if (side_i.zero) begin
      removed_d = '0;
      cw_d      = '0;
      ch_d      = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    cw_q      <= cw_d;
    ch_q      <= ch_d;
    mode_q    <= side_i.mode;
    zero_q    <= side_i.zero;
    shift_q   <= shift_d;
  end

  // leading crop: multiple of the alignment nearest half, ties go up if it fits
  dim_t               align, half, lo, lead, trail;
  logic [DimBits:0]   hi, up_gap, dn_gap;
  res_t               res_d;

  always_comb begin
    align  = dim_t'(1) << shift_q;
    half   = removed_q >> 1;
    lo     = half & ~(align - dim_t'(1));
    hi     = {1'b0, lo} + {1'b0, align};
    up_gap = hi - {1'b0, half};
    dn_gap = {1'b0, half} - {1'b0, lo};
    lead   = ((hi <= {1'b0, removed_q}) && (up_gap <= dn_gap)) ? hi[DimBits-1:0] : lo;
    trail  = removed_q - lead;

    res_d             = '0;
    res_d.width       = cw_q;
    res_d.height      = ch_q;
    res_d.status      = zero_q;
    if (!zero_q) begin
      unique case (mode_q)
        MODE_WIDE: begin
          res_d.left_px  = lead;
          res_d.right_px = trail;
        end
        MODE_TALL: begin
          res_d.top_px    = lead;
          res_d.bottom_px = trail;
        end
        default: begin
          res_d.left_px = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vb_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[hdl/accc_checker.sv]
// Port-level checker for the crop calculator, bound to the top level.
`default_nettype none

module accc_checker import accc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [DimBits-1:0]  frame_width_i,
  input wire logic [DimBits-1:0]  frame_height_i,
  input wire logic                done_o,
  input wire logic [DimBits-1:0]  crop_left_px_o,
  input wire logic [DimBits-1:0]  crop_right_px_o,
  input wire logic [DimBits-1:0]  crop_top_px_o,
  input wire logic [DimBits-1:0]  crop_bottom_px_o,
  input wire logic [DimBits-1:0]  cropped_width_o,
  input wire logic [DimBits-1:0]  cropped_height_o,
  input wire logic                status_o,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [AddrBits-1:0] paddr,
  input wire logic [DataBits-1:0] pwdata,
  input wire logic [DataBits-1:0] prdata,
  input wire logic                pready
);

  // every accepted request yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result missing after request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without request");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (crop_left_px_o == '0 && crop_right_px_o == '0 &&
      crop_top_px_o == '0 && crop_bottom_px_o == '0 &&
      cropped_width_o == '0 && cropped_height_o == '0))
    else $error("error result carries data");

  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((crop_left_px_o == '0 && crop_right_px_o == '0) ||
      (crop_top_px_o == '0 && crop_bottom_px_o == '0)))
    else $error("crop on both axes");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !status_o) |-> (cropped_width_o != '0 && cropped_height_o != '0))
    else $error("ok result with empty size");

endmodule

bind aspect_center_crop_calc_core accc_checker u_accc_checker (.*);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the aspect-ratio center crop calculator.
`timescale 1ns / 100ps

module tb;
  import accc_pkg::*;

  // Holds the crop results still to come and the register copy they follow.
  class crop_scoreboard;
    dim_t                 tw;
    dim_t                 th;
    logic [ShiftBits-1:0] sx;
    logic [ShiftBits-1:0] sy;
    res_t                 pending_crops[$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          n_zero;
    int unsigned          n_wide;
    int unsigned          n_tall;
    int unsigned          n_equal;

    function new();
      tw = 16'd1;
      th = 16'd1;
      sx = 2'd1;
      sy = 2'd1;
      mismatches = 0;
      checked = 0;
      n_zero = 0;
      n_wide = 0;
      n_tall = 0;
      n_equal = 0;
    endfunction

    function void set_reg(logic [RegIdxBits-1:0] idx, logic [DataBits-1:0] val);
      case (idx)
        RegTargetW: tw = val[DimBits-1:0];
        RegTargetH: th = val[DimBits-1:0];
        RegShiftX:  sx = val[ShiftBits-1:0];
        RegShiftY:  sy = val[ShiftBits-1:0];
        default: ;
      endcase
    endfunction

    // leading crop: multiple of 2^shift nearest half, upper one on a tie if it fits
    function longint unsigned lead_crop(longint unsigned removed,
                                        logic [ShiftBits-1:0] shift);
      longint unsigned align;
      longint unsigned half;
      longint unsigned lo;
      longint unsigned hi;
      align = 64'd1 << shift;
      half = removed / 2;
      lo = (half / align) * align;
      hi = lo + align;
      if (hi <= removed && (hi - half) <= (half - lo)) return hi;
      return lo;
    endfunction

    function res_t calc_crop(dim_t w, dim_t h);
      res_t            r;
      longint unsigned wl;
      longint unsigned hl;
      longint unsigned src;
      longint unsigned dst;
      longint unsigned cw;
      longint unsigned ch;
      longint unsigned removed;
      longint unsigned lead;
      r = '0;
      wl = w;
      hl = h;
      if (w == 0 || h == 0 || tw == 0 || th == 0) begin
        r.status = 1'b1;
      end else begin
        cw = wl;
        ch = hl;
        src = wl * th;
        dst = longint'(tw) * hl;
        if (src > dst) begin
          cw = (hl * tw) / th;
          if (cw == 0) cw = 1;
          removed = wl - cw;
          lead = lead_crop(removed, sx);
          r.left_px = dim_t'(lead);
          r.right_px = dim_t'(removed - lead);
        end else if (src < dst) begin
          ch = (wl * th) / tw;
          if (ch == 0) ch = 1;
          removed = hl - ch;
          lead = lead_crop(removed, sy);
          r.top_px = dim_t'(lead);
          r.bottom_px = dim_t'(removed - lead);
        end
        r.width = dim_t'(cw);
        r.height = dim_t'(ch);
      end
      return r;
    endfunction

    function void note_frame(dim_t w, dim_t h);
      pending_crops.push_back(calc_crop(w, h));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("ERROR %0t: %s (got %0d, expected %0d)", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_crop(res_t got);
      res_t want;
      if (pending_crops.size() == 0) begin
        report("result with no request pending", 0, 0);
        return;
      end
      want = pending_crops.pop_front();
      checked++;
      if (want.status) n_zero++;
      else if (want.left_px != 0 || want.right_px != 0) n_wide++;
      else if (want.top_px != 0 || want.bottom_px != 0) n_tall++;
      else n_equal++;
      if (got.left_px !== want.left_px)
        report("crop_left_px", got.left_px, want.left_px);
      if (got.right_px !== want.right_px)
        report("crop_right_px", got.right_px, want.right_px);
      if (got.top_px !== want.top_px)
        report("crop_top_px", got.top_px, want.top_px);
      if (got.bottom_px !== want.bottom_px)
        report("crop_bottom_px", got.bottom_px, want.bottom_px);
      if (got.width !== want.width)
        report("cropped_width", got.width, want.width);
      if (got.height !== want.height)
        report("cropped_height", got.height, want.height);
      if (got.status !== want.status)
        report("status", got.status, want.status);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  dim_t                frame_width_i = '0;
  dim_t                frame_height_i = '0;
  logic                done_o;
  dim_t                crop_left_px_o;
  dim_t                crop_right_px_o;
  dim_t                crop_top_px_o;
  dim_t                crop_bottom_px_o;
  dim_t                cropped_width_o;
  dim_t                cropped_height_o;
  logic                status_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  crop_scoreboard sb;
  bit             no_idle = 1'b0;
  int unsigned    n_sent = 0;
  int unsigned    n_settings = 0;

  aspect_center_crop_calc_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .frame_width_i    (frame_width_i),
    .frame_height_i   (frame_height_i),
    .done_o           (done_o),
    .crop_left_px_o   (crop_left_px_o),
    .crop_right_px_o  (crop_right_px_o),
    .crop_top_px_o    (crop_top_px_o),
    .crop_bottom_px_o (crop_bottom_px_o),
    .cropped_width_o  (cropped_width_o),
    .cropped_height_o (cropped_height_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.check_crop('{left_px: crop_left_px_o, right_px: crop_right_px_o,
                      top_px: crop_top_px_o, bottom_px: crop_bottom_px_o,
                      width: cropped_width_o, height: cropped_height_o,
                      status: status_o});
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function dim_t extreme_dim();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // one request; returns at the edge where it was taken, start left high
  task send_frame(dim_t w, dim_t h);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    frame_width_i <= w;
    frame_height_i <= h;
    do @(posedge clk_i); while (busy);
    sb.note_frame(w, h);
    n_sent++;
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_crops.size() != 0);
  endtask

  task apb_access(bit wr, logic [RegIdxBits-1:0] idx, logic [DataBits-1:0] wdata,
                  output logic [DataBits-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= AddrBits'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task write_reg(logic [RegIdxBits-1:0] idx, logic [DataBits-1:0] value);
    logic [DataBits-1:0] rd;
    logic [DataBits-1:0] mask;
    apb_access(1'b1, idx, value, rd);
    sb.set_reg(idx, value);
    apb_access(1'b0, idx, $urandom, rd);
    mask = (idx == RegShiftX || idx == RegShiftY) ? 32'h3 : 32'hFFFF;
    if (rd !== (value & mask)) sb.report("register readback", rd, value & mask);
  endtask

  // upper data bits carry noise; the registers must drop them
  task configure(dim_t tw, dim_t th, logic [ShiftBits-1:0] sx, logic [ShiftBits-1:0] sy);
    drain();
    write_reg(RegTargetW, {16'($urandom), tw});
    write_reg(RegTargetH, {16'($urandom), th});
    write_reg(RegShiftX, {30'($urandom), sx});
    write_reg(RegShiftY, {30'($urandom), sy});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task random_setting(bit zero_target);
    dim_t tw;
    dim_t th;
    case ($urandom_range(0, 7))
      0: begin tw = 16'd16; th = 16'd9; end
      1: begin tw = 16'd4; th = 16'd3; end
      2: begin tw = 16'd9; th = 16'd16; end
      3: begin tw = 16'd21; th = 16'd9; end
      4: begin tw = dim_t'($urandom_range(1, 32)); th = dim_t'($urandom_range(1, 32)); end
      5: begin tw = 16'hFFFF; th = dim_t'($urandom_range(1, 65535)); end
      6: begin tw = dim_t'($urandom_range(1, 65535)); th = 16'hFFFF; end
      default: begin
        tw = dim_t'($urandom_range(1, 65535));
        th = dim_t'($urandom_range(1, 65535));
      end
    endcase
    if (zero_target) begin
      if ($urandom_range(0, 1)) tw = '0;
      else th = '0;
    end
    configure(tw, th, ShiftBits'($urandom_range(0, 3)), ShiftBits'($urandom_range(0, 3)));
  endtask

  task random_frame();
    dim_t            w;
    dim_t            h;
    int unsigned     k;
    longint signed   guess;
    case ($urandom_range(0, 9))
      0, 1, 2: begin w = dim_t'($urandom); h = dim_t'($urandom); end
      3: begin w = dim_t'($urandom_range(0, 20)); h = dim_t'($urandom_range(0, 20)); end
      4: begin
        // exact target aspect
        if (sb.tw != 0 && sb.th != 0) begin
          k = $urandom_range(1, 65535 / ((sb.tw > sb.th) ? sb.tw : sb.th));
          w = dim_t'(k * sb.tw);
          h = dim_t'(k * sb.th);
        end else begin
          w = dim_t'($urandom);
          h = dim_t'($urandom);
        end
      end
      5: begin w = dim_t'($urandom_range(1, 4096)); h = dim_t'($urandom_range(1, 4096)); end
      6: begin w = extreme_dim(); h = extreme_dim(); end
      7: begin w = dim_t'($urandom); h = dim_t'($urandom_range(0, 15)); end
      8: begin w = dim_t'($urandom_range(0, 15)); h = dim_t'($urandom); end
      default: begin
        // just off the target aspect, exercises the rounding of the split
        w = dim_t'($urandom_range(1, 65535));
        if (sb.tw != 0) begin
          guess = (longint'(w) * sb.th) / sb.tw + $urandom_range(0, 4) - 2;
          if (guess < 1) guess = 1;
          if (guess > 65535) guess = 65535;
          h = dim_t'(guess);
        end else begin
          h = dim_t'($urandom);
        end
      end
    endcase
    send_frame(w, h);
  endtask

  initial begin
    int unsigned n_items;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    // reset setting 1:1, alignment 2: zero sizes, extremes, tie splits
    send_frame(16'd0, 16'd0);
    send_frame(16'd0, 16'd77);
    send_frame(16'd77, 16'd0);
    send_frame(16'd1, 16'd1);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'hFFFF, 16'd1);
    send_frame(16'd1, 16'hFFFF);
    send_frame(16'd10, 16'd4);
    send_frame(16'd4, 16'd11);
    send_frame(16'd6, 16'd4);
    configure(16'd16, 16'd9, 2'd0, 2'd3);
    send_frame(16'd1920, 16'd1080);
    send_frame(16'd1920, 16'd1200);
    send_frame(16'd1280, 16'd1024);
    send_frame(16'd2, 16'hFFFF);
    configure(16'hFFFF, 16'd1, 2'd3, 2'd0);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd2, 16'd1);
    configure(16'd1, 16'hFFFF, 2'd0, 2'd3);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd1, 16'd2);
    configure(16'd0, 16'd5, 2'd1, 2'd1);
    send_frame(16'd100, 16'd100);
    send_frame(16'd0, 16'd0);
    configure(16'd7, 16'd0, 2'd2, 2'd2);
    send_frame(16'd100, 16'd100);

    for (int p = 0; p < 8; p++) begin
      random_setting(p == 5);
      no_idle = (p == 2 || p == 6);
      n_items = (p == 5) ? 50 : 220;
      repeat (n_items) random_frame();
    end
    no_idle = 1'b0;

    drain();
    repeat (Latency + 8) @(posedge clk_i);

    $display("Sent %0d frame sizes over %0d register settings; %0d results checked.",
             n_sent, n_settings, sb.checked);
    $display("Results: %0d width crops, %0d height crops, %0d uncropped, %0d zero-size.",
             sb.n_wide, sb.n_tall, sb.n_equal, sb.n_zero);
    if (sb.mismatches == 0 && sb.pending_crops.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
